// ===== sv/json_structure_tokenizer_assert.svh =====
// Assertion macros for the JSON structure tokenizer.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef JSON_STRUCTURE_TOKENIZER_ASSERT_SVH
`define JSON_STRUCTURE_TOKENIZER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define JST_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("json tokenizer check failed");

// A condition that must never be seen outside reset.
`define JST_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("json tokenizer forbidden condition seen");

`endif

// ===== sv/jst_pkg.sv =====
`default_nettype none

package jst_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_DEPTH_DEF = 32;
  localparam int ID_BITS_DEF   = 16;
  localparam int POS_BITS_DEF  = 20;

  // Result queue.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_LVL_BITS = $clog2(FIFO_DEPTH + 1);

  // Characters of interest.
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Record kinds.
  localparam logic [1:0] REC_NODE   = 2'd0;
  localparam logic [1:0] REC_RETYPE = 2'd1;
  localparam logic [1:0] REC_DONE   = 2'd2;
  localparam logic [1:0] REC_ERROR  = 2'd3;

  // Node types.
  localparam logic [1:0] TYPE_STR  = 2'd0;
  localparam logic [1:0] TYPE_PRIM = 2'd1;
  localparam logic [1:0] TYPE_OBJ  = 2'd2;
  localparam logic [1:0] TYPE_ARR  = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNBALANCED = 3'd1;
  localparam logic [2:0] ERR_COLON_ARR  = 3'd2;
  localparam logic [2:0] ERR_NO_KEY     = 3'd3;
  localparam logic [2:0] ERR_STRING     = 3'd4;
  localparam logic [2:0] ERR_ESCAPE     = 3'd5;
  localparam logic [2:0] ERR_PRIM       = 3'd6;
  localparam logic [2:0] ERR_OVERFLOW   = 3'd7;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_STRING = 2'd1,
    MODE_ESCAPE = 2'd2,
    MODE_PRIM   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  rec_kind;
    logic [15:0] node_id;
    logic [15:0] parent_id;
    logic [1:0]  node_type;
    logic [19:0] start_pos;
    logic [19:0] value_length;
    logic [2:0]  error_code;
    logic        last_result;
  } rec_t;

  // Up to two records produced by one item, in order.
  typedef struct packed {
    logic [1:0]      cnt;
    rec_t [1:0]      recs;
  } rec_pair_t;

endpackage

`default_nettype wire

// ===== sv/json_structure_tokenizer.sv =====
// JSON structure tokenizer.
// Input channel item_valid/item_ready/item carries one byte of JSON text per
// item, with last_byte marking the final byte of a document. Output channel
// rec_valid/rec_ready/rec carries node, retype, done and error records.
// Each byte is decoded in the cycle in which it is accepted, against the top
// entry of the open-container stack and the scan mode, and its zero, one or
// two records are written into a four-entry result queue. The records are
// registered there, and rec shows the record at the head of the queue.
// A new byte is accepted in every cycle while the queue has room for two
// records, so a stream of bytes that each cause at most one record runs at
// one item per cycle while the receiver holds rec_ready high; the queue's
// single read port limits the output to one record per cycle.
// When the receiver stalls, records wait in the queue and item_ready falls
// once fewer than two slots remain free.
// Reset (rst, synchronous) empties the queue and returns the scanner to the
// start of a document: level 0, root id 0, next node id 1, offset 0. The
// same state is restored after every byte that carries last_byte.
`default_nettype none

module json_structure_tokenizer #(
  parameter int MAX_DEPTH = jst_pkg::MAX_DEPTH_DEF,
  parameter int ID_BITS   = jst_pkg::ID_BITS_DEF,
  parameter int POS_BITS  = jst_pkg::POS_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire jst_pkg::item_t item,
  output logic                rec_valid,
  input  wire logic           rec_ready,
  output jst_pkg::rec_t       rec
);

  `include "json_structure_tokenizer_assert.svh"

  logic                                 accept;
  logic                                 pop;
  jst_pkg::rec_pair_t                   recs;
  logic [jst_pkg::FIFO_LVL_BITS-1:0]    level;

  // Room for the worst case of two records per byte.
  assign item_ready = (level <= jst_pkg::FIFO_LVL_BITS'(jst_pkg::FIFO_DEPTH - 2));
  assign accept     = item_valid && item_ready;
  assign rec_valid  = (level != '0);
  assign pop        = rec_valid && rec_ready;

  jst_core #(
    .MAX_DEPTH (MAX_DEPTH),
    .ID_BITS   (ID_BITS),
    .POS_BITS  (POS_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .en   (accept),
    .item (item),
    .out  (recs)
  );

  jst_out_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .din   (recs),
    .pop   (pop),
    .head  (rec),
    .level (level)
  );

  // The queue never holds more records than it has slots.
  `JST_NEVER(a_level_bound, level > jst_pkg::FIFO_LVL_BITS'(jst_pkg::FIFO_DEPTH))
  // With no byte taken and no record delivered, the queue fill stays put.
  `JST_CHECK(a_level_hold, (!accept && !pop) |=> $stable(level))
  // A done record always closes the results of its byte.
  `JST_CHECK(a_done_last, (rec_valid && rec.rec_kind == jst_pkg::REC_DONE) |-> rec.last_result)
  // The queue starts empty after reset.
  `JST_CHECK(a_reset_empty, $past(rst) |-> (level == '0))

endmodule

`default_nettype wire

// ===== sv/jst_core.sv =====
`default_nettype none

module jst_core #(
  parameter int MAX_DEPTH = jst_pkg::MAX_DEPTH_DEF,
  parameter int ID_BITS   = jst_pkg::ID_BITS_DEF,
  parameter int POS_BITS  = jst_pkg::POS_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire jst_pkg::item_t    item,
  output jst_pkg::rec_pair_t     out
);

  localparam int LVL_BITS = $clog2(MAX_DEPTH);

  // Scanner state.
  jst_pkg::mode_t       mode, mode_next;
  logic [LVL_BITS-1:0]  nest, nest_next;
  logic                 kp, kp_next;
  logic                 khc, khc_next;
  logic [POS_BITS-1:0]  tstart, tstart_next;
  logic [POS_BITS:0]    pos, pos_next;
  logic [ID_BITS:0]     next_id, next_id_next;
  logic                 err, err_next;

  // Open-container stack, read only at the current level.
  logic [ID_BITS-1:0]   stk_id   [MAX_DEPTH];
  logic                 stk_arr  [MAX_DEPTH];
  logic [ID_BITS-1:0]   stk_lc   [MAX_DEPTH];
  logic [MAX_DEPTH-1:0] stk_lcv;

  logic [ID_BITS-1:0]   top_id;
  logic                 top_arr;
  logic                 top_lcv;
  logic [ID_BITS-1:0]   top_lc;

  logic                 lc_we;
  logic [ID_BITS-1:0]   lc_wid;
  logic                 push_we;
  logic [ID_BITS-1:0]   push_id;
  logic                 push_arr;
  logic                 push_lcv;
  logic [ID_BITS-1:0]   push_lcid;
  logic                 clear_lc;
  logic [LVL_BITS-1:0]  push_idx;

  jst_pkg::rec_t [1:0]  recs;
  logic [1:0]           k;
  logic                 err_this;
  logic                 do_make;
  logic                 do_norm;
  logic [1:0]           make_type;
  logic [ID_BITS-1:0]   nid;
  logic [ID_BITS-1:0]   parent;
  logic [1:0]           open_type;
  logic                 is_term;
  logic                 is_prim_start;

  function automatic logic [15:0] fit_id(input logic [ID_BITS:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[15:0];
  endfunction

  function automatic logic [19:0] fit_pos(input logic [POS_BITS:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[19:0];
  endfunction

  function automatic jst_pkg::rec_t mk_rec(input logic [1:0] kind, input logic [15:0] id,
                                           input logic [15:0] par, input logic [1:0] typ,
                                           input logic [19:0] start, input logic [19:0] len,
                                           input logic [2:0] code);
    jst_pkg::rec_t r;
    r.rec_kind     = kind;
    r.node_id      = id;
    r.parent_id    = par;
    r.node_type    = typ;
    r.start_pos    = start;
    r.value_length = len;
    r.error_code   = code;
    r.last_result  = 1'b0;
    return r;
  endfunction

  assign top_id   = (nest == '0) ? '0 : stk_id[nest];
  assign top_arr  = (nest == '0) ? 1'b0 : stk_arr[nest];
  assign top_lcv  = stk_lcv[nest];
  assign top_lc   = stk_lc[nest];
  assign push_idx = LVL_BITS'(nest + 1'b1);

  assign is_term = (item.byte_in == jst_pkg::CH_RBRACK) || (item.byte_in == jst_pkg::CH_RBRACE) ||
                   (item.byte_in == jst_pkg::CH_TAB) || (item.byte_in == jst_pkg::CH_CR) ||
                   (item.byte_in == jst_pkg::CH_LF) || (item.byte_in == jst_pkg::CH_SPACE) ||
                   (item.byte_in == jst_pkg::CH_COMMA);
  assign is_prim_start = (item.byte_in == jst_pkg::CH_MINUS) || (item.byte_in == jst_pkg::CH_T) ||
                         (item.byte_in == jst_pkg::CH_F) || (item.byte_in == jst_pkg::CH_N) ||
                         ((item.byte_in >= jst_pkg::CH_ZERO) && (item.byte_in <= jst_pkg::CH_NINE));

  always_comb begin
    mode_next    = mode;
    nest_next    = nest;
    kp_next      = kp;
    khc_next     = khc;
    tstart_next  = tstart;
    pos_next     = pos;
    next_id_next = next_id;
    err_next     = err;
    lc_we        = 1'b0;
    lc_wid       = next_id[ID_BITS-1:0];
    push_we      = 1'b0;
    push_id      = '0;
    push_arr     = 1'b0;
    push_lcv     = 1'b0;
    push_lcid    = '0;
    clear_lc     = 1'b0;
    recs         = '0;
    k            = 2'd0;
    err_this     = 1'b0;
    do_make      = 1'b0;
    do_norm      = 1'b0;
    make_type    = jst_pkg::TYPE_STR;
    nid          = '0;
    parent       = '0;
    open_type    = (item.byte_in == jst_pkg::CH_LBRACK) ? jst_pkg::TYPE_ARR : jst_pkg::TYPE_OBJ;

    if (!err) begin
      if (pos[POS_BITS]) begin
        recs[k[0]] = mk_rec(jst_pkg::REC_ERROR, '0, '0, '0, fit_pos(pos), '0,
                            jst_pkg::ERR_OVERFLOW);
        k = k + 2'd1;
        err_next = 1'b1;
        err_this = 1'b1;
        mode_next = jst_pkg::MODE_NORMAL;
      end else begin
        case (mode)
          jst_pkg::MODE_STRING: begin
            if (item.byte_in == jst_pkg::CH_QUOTE) begin
              mode_next = jst_pkg::MODE_NORMAL;
              do_make = 1'b1;
              make_type = jst_pkg::TYPE_STR;
            end else if (item.byte_in == jst_pkg::CH_BSLASH) begin
              mode_next = jst_pkg::MODE_ESCAPE;
            end
          end
          jst_pkg::MODE_ESCAPE: begin
            mode_next = jst_pkg::MODE_STRING;
          end
          jst_pkg::MODE_PRIM: begin
            if (is_term) begin
              mode_next = jst_pkg::MODE_NORMAL;
              do_make = 1'b1;
              make_type = jst_pkg::TYPE_PRIM;
              do_norm = 1'b1;
            end
          end
          default: begin
            do_norm = 1'b1;
          end
        endcase
      end
    end

    // Creation of a string or primitive node.
    if (do_make) begin
      if (next_id[ID_BITS]) begin
        recs[k[0]] = mk_rec(jst_pkg::REC_ERROR, '0, '0, '0, fit_pos(pos), '0,
                            jst_pkg::ERR_OVERFLOW);
        k = k + 2'd1;
        err_next = 1'b1;
        err_this = 1'b1;
        mode_next = jst_pkg::MODE_NORMAL;
      end else begin
        nid = next_id[ID_BITS-1:0];
        next_id_next = next_id + 1'b1;
        if (kp && top_lcv) begin
          parent = top_lc;
          khc_next = 1'b1;
        end else begin
          parent = top_id;
          lc_we = 1'b1;
          lc_wid = nid;
        end
        recs[k[0]] = mk_rec(jst_pkg::REC_NODE, fit_id({1'b0, nid}), fit_id({1'b0, parent}),
                            make_type, fit_pos({1'b0, tstart}),
                            fit_pos({1'b0, POS_BITS'(pos[POS_BITS-1:0] - tstart)}),
                            jst_pkg::ERR_NONE);
        k = k + 2'd1;
      end
    end

    // Structural characters in normal scanning.
    if (do_norm && !err_this) begin
      case (item.byte_in)
        jst_pkg::CH_LBRACE, jst_pkg::CH_LBRACK: begin
          if ((LVL_BITS+1)'(nest) + 1'b1 >= (LVL_BITS+1)'(MAX_DEPTH)) begin
            recs[k[0]] = mk_rec(jst_pkg::REC_ERROR, '0, '0, '0, fit_pos(pos), '0,
                                jst_pkg::ERR_OVERFLOW);
            k = k + 2'd1;
            err_next = 1'b1;
            err_this = 1'b1;
            mode_next = jst_pkg::MODE_NORMAL;
          end else if (kp_next && top_lcv) begin
            // Bracket after a colon: the key itself becomes the container.
            nid = top_lc;
            push_lcv = khc_next;
            push_lcid = ID_BITS'(next_id_next - 1'b1);
            recs[k[0]] = mk_rec(jst_pkg::REC_RETYPE, fit_id({1'b0, nid}),
                                fit_id({1'b0, top_id}), open_type, fit_pos(pos), '0,
                                jst_pkg::ERR_NONE);
            k = k + 2'd1;
          end else if (next_id_next[ID_BITS]) begin
            recs[k[0]] = mk_rec(jst_pkg::REC_ERROR, '0, '0, '0, fit_pos(pos), '0,
                                jst_pkg::ERR_OVERFLOW);
            k = k + 2'd1;
            err_next = 1'b1;
            err_this = 1'b1;
            mode_next = jst_pkg::MODE_NORMAL;
          end else begin
            nid = next_id_next[ID_BITS-1:0];
            next_id_next = next_id_next + 1'b1;
            lc_we = 1'b1;
            lc_wid = nid;
            recs[k[0]] = mk_rec(jst_pkg::REC_NODE, fit_id({1'b0, nid}),
                                fit_id({1'b0, top_id}), open_type, fit_pos(pos), '0,
                                jst_pkg::ERR_NONE);
            k = k + 2'd1;
          end
          if (!err_this) begin
            nest_next = push_idx;
            push_we = 1'b1;
            push_id = nid;
            push_arr = (open_type == jst_pkg::TYPE_ARR);
            kp_next = 1'b0;
            khc_next = 1'b0;
          end
        end
        jst_pkg::CH_RBRACE, jst_pkg::CH_RBRACK: begin
          if (nest == '0) begin
            recs[k[0]] = mk_rec(jst_pkg::REC_ERROR, '0, '0, '0, fit_pos(pos), '0,
                                jst_pkg::ERR_UNBALANCED);
            k = k + 2'd1;
            err_next = 1'b1;
            err_this = 1'b1;
            mode_next = jst_pkg::MODE_NORMAL;
          end else begin
            nest_next = nest - 1'b1;
            kp_next = 1'b0;
            khc_next = 1'b0;
          end
        end
        jst_pkg::CH_QUOTE: begin
          mode_next = jst_pkg::MODE_STRING;
          tstart_next = pos[POS_BITS-1:0] + 1'b1;
        end
        jst_pkg::CH_COLON: begin
          if (top_arr || !top_lcv) begin
            recs[k[0]] = mk_rec(jst_pkg::REC_ERROR, '0, '0, '0, fit_pos(pos), '0,
                                top_arr ? jst_pkg::ERR_COLON_ARR : jst_pkg::ERR_NO_KEY);
            k = k + 2'd1;
            err_next = 1'b1;
            err_this = 1'b1;
            mode_next = jst_pkg::MODE_NORMAL;
          end else begin
            if (!kp_next) begin
              khc_next = 1'b0;
            end
            kp_next = 1'b1;
          end
        end
        jst_pkg::CH_COMMA: begin
          kp_next = 1'b0;
          khc_next = 1'b0;
        end
        default: begin
          if (is_prim_start) begin
            mode_next = jst_pkg::MODE_PRIM;
            tstart_next = pos[POS_BITS-1:0];
          end
        end
      endcase
    end

    if (item.last_byte) begin
      if (!err_next && (mode_next != jst_pkg::MODE_NORMAL)) begin
        recs[k[0]] = mk_rec(jst_pkg::REC_ERROR, '0, '0, '0, fit_pos(pos), '0,
                            (mode_next == jst_pkg::MODE_STRING) ? jst_pkg::ERR_STRING :
                            (mode_next == jst_pkg::MODE_ESCAPE) ? jst_pkg::ERR_ESCAPE :
                                                                  jst_pkg::ERR_PRIM);
        k = k + 2'd1;
        err_this = 1'b1;
      end
      if (!err_this) begin
        recs[k[0]] = mk_rec(jst_pkg::REC_DONE, fit_id(next_id_next - 1'b1), '0, '0, '0, '0,
                            jst_pkg::ERR_NONE);
        k = k + 2'd1;
      end
      // The next document starts from the reset state.
      mode_next    = jst_pkg::MODE_NORMAL;
      nest_next    = '0;
      kp_next      = 1'b0;
      khc_next     = 1'b0;
      tstart_next  = '0;
      pos_next     = '0;
      next_id_next = (ID_BITS+1)'(1);
      err_next     = 1'b0;
      clear_lc     = 1'b1;
    end else begin
      pos_next = pos + 1'b1;
    end

    if (k != 2'd0) begin
      recs[k[1]].last_result = 1'b1;
    end
    out.cnt  = k;
    out.recs = recs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= jst_pkg::MODE_NORMAL;
      nest    <= '0;
      kp      <= 1'b0;
      khc     <= 1'b0;
      tstart  <= '0;
      pos     <= '0;
      next_id <= (ID_BITS+1)'(1);
      err     <= 1'b0;
      stk_lcv <= '0;
    end else if (en) begin
      mode    <= mode_next;
      nest    <= nest_next;
      kp      <= kp_next;
      khc     <= khc_next;
      tstart  <= tstart_next;
      pos     <= pos_next;
      next_id <= next_id_next;
      err     <= err_next;
      if (clear_lc) begin
        stk_lcv <= '0;
      end else begin
        if (lc_we) begin
          stk_lcv[nest] <= 1'b1;
        end
        if (push_we) begin
          stk_lcv[push_idx] <= push_lcv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (lc_we) begin
        stk_lc[nest] <= lc_wid;
      end
      if (push_we) begin
        stk_id[push_idx]  <= push_id;
        stk_arr[push_idx] <= push_arr;
        stk_lc[push_idx]  <= push_lcid;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/jst_out_fifo.sv =====
`default_nettype none

module jst_out_fifo (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 push,
  input  wire jst_pkg::rec_pair_t                   din,
  input  wire logic                                 pop,
  output jst_pkg::rec_t                             head,
  output logic [jst_pkg::FIFO_LVL_BITS-1:0]         level
);

  jst_pkg::rec_t                      mem [jst_pkg::FIFO_DEPTH];
  logic [jst_pkg::FIFO_PTR_BITS-1:0]  wp;
  logic [jst_pkg::FIFO_PTR_BITS-1:0]  rp;
  logic [1:0]                         n_in;

  assign n_in = push ? din.cnt : 2'd0;
  assign head = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      wp    <= wp + jst_pkg::FIFO_PTR_BITS'(n_in);
      rp    <= rp + jst_pkg::FIFO_PTR_BITS'(pop);
      level <= level + jst_pkg::FIFO_LVL_BITS'(n_in) - jst_pkg::FIFO_LVL_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem[wp] <= din.recs[0];
    end
    if (n_in == 2'd2) begin
      mem[wp + 1'b1] <= din.recs[1];
    end
  end

endmodule

`default_nettype wire
